// ===== hdl/phase_shifted_clock_pair_top_macros.svh =====
// Assertion macros used by the phase shifted clock pair sequencer.
`ifndef PHASE_SHIFTED_CLOCK_PAIR_TOP_MACROS_SVH
`define PHASE_SHIFTED_CLOCK_PAIR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PSCP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PSCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pscp_pkg.sv =====
// Package: types, microcode format and constants of the phase shifted clock pair.
package pscp_pkg;

	// Phase accumulator width
	localparam int PHASE_BITS = 32;

	// Program counter
	localparam int PC_W = 3;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_HORNER = 3'd0;
	localparam pc_t PC_MANT   = 3'd1;
	localparam pc_t PC_SCALE  = 3'd2;
	localparam pc_t PC_SHIFT  = 3'd3;
	localparam pc_t PC_OUT    = 3'd4;

	// Multiplier operand selects
	typedef enum logic [1:0] {A_ACC, A_STEP, A_SMAG} asel_t;
	typedef enum logic [1:0] {B_F, B_ACC, B_RECIP} bsel_t;

	// Accumulator update
	typedef enum logic [1:0] {ACC_HOLD, ACC_COEF, ACC_ONE} accop_t;

	// Sequencing
	typedef enum logic [1:0] {JMP_NEXT, JMP_LOOP, JMP_END} jmp_t;

	typedef struct packed {
		asel_t  asel;
		bsel_t  bsel;
		accop_t acc_op;
		logic   prod_we;
		logic   sq_we;
		logic   phase_we;
		logic   out_we;
		jmp_t   jmp;
		pc_t    target;
	} ucode_t;

	// Control from sequencer to datapath
	typedef struct packed {
		logic       load;
		logic       run;
		ucode_t     uw;
		logic [1:0] k;
	} ctl_t;

	typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

	// Configuration register indexes
	localparam logic [7:0] CFG_RATE_KNOB   = 8'd0;
	localparam logic [7:0] CFG_SHIFT_KNOB  = 8'd1;
	localparam logic [7:0] CFG_PULSE_WIDTH = 8'd2;
	localparam logic [7:0] CFG_STEP_PER_HZ = 8'd3;

	// Register reset values
	localparam logic signed [14:0] RATE_KNOB_RST   = 15'sd2048;
	localparam logic [16:0]        SHIFT_KNOB_RST  = 17'd32768;
	localparam logic [15:0]        PULSE_WIDTH_RST = 16'd16384;
	localparam logic [31:0]        STEP_PER_HZ_RST = 32'd89478;

	// Rate volts clamp and octave offset, Q11
	localparam logic signed [17:0] V_LIMIT  = 18'sd20480;
	localparam logic signed [17:0] V_OFFSET = 18'sd40960;

	// Shift clamp, Q16
	localparam logic signed [18:0] SHIFT_ONE = 19'sd65536;

	// Exp2 polynomial, Q30
	localparam logic [30:0] EXP_ONE = 31'd1073741824;
	localparam logic [30:0] EXP_C4  = 31'd2017669;
	localparam logic [1:0]  HORNER_LAST = 2'd3;

	// ceil(2^24 / 5): exact floor division by 5 below 2^22
	localparam logic [21:0] RECIP5 = 22'd3355444;
	localparam int RECIP5_SHIFT = 24;

	// Shift amount base for the increment: 50 - octave
	localparam logic [5:0] INC_SHIFT_BASE = 6'd50;

	function automatic logic [29:0] exp_coef(input logic [1:0] k);
		logic [29:0] c;
		case (k)
			2'd0:    c = 30'd744265964;
			2'd1:    c = 30'd257869406;
			2'd2:    c = 30'd59934023;
			2'd3:    c = 30'd9654762;
			default: c = 30'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/pscp_if.sv =====
// Channel interfaces: sample ticks in, gate results out.
interface pscp_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] rate_cv;
	logic               rate_cv_present;
	logic signed [15:0] shift_cv;
	logic               shift_cv_present;

	modport source (output valid, rate_cv, rate_cv_present, shift_cv, shift_cv_present,
		input ready);
	modport sink (input valid, rate_cv, rate_cv_present, shift_cv, shift_cv_present,
		output ready);
endinterface

interface pscp_gate_if;
	logic valid;
	logic ready;
	logic alpha_gate;
	logic beta_gate;
	logic combined_gate;

	modport source (output valid, alpha_gate, beta_gate, combined_gate, input ready);
	modport sink (input valid, alpha_gate, beta_gate, combined_gate, output ready);
endinterface

// ===== hdl/pscp_ucode_rom.sv =====
// Microcode ROM: one control word per program step.
module pscp_ucode_rom import pscp_pkg::*; (
	input  pc_t    pc,
	output ucode_t uw
);

	always_comb begin
		uw = '{asel: A_ACC, bsel: B_F, acc_op: ACC_HOLD, prod_we: 1'b0, sq_we: 1'b0,
			phase_we: 1'b0, out_we: 1'b0, jmp: JMP_END, target: PC_HORNER};
		case (pc)
			// acc = coef[k] + acc*f, repeat while k != 0
			PC_HORNER: begin
				uw.asel   = A_ACC;
				uw.bsel   = B_F;
				uw.acc_op = ACC_COEF;
				uw.jmp    = JMP_LOOP;
				uw.target = PC_HORNER;
			end
			// mantissa = 1.0 + acc*f
			PC_MANT: begin
				uw.asel   = A_ACC;
				uw.bsel   = B_F;
				uw.acc_op = ACC_ONE;
				uw.jmp    = JMP_NEXT;
			end
			// step_per_hz * mantissa
			PC_SCALE: begin
				uw.asel    = A_STEP;
				uw.bsel    = B_ACC;
				uw.prod_we = 1'b1;
				uw.jmp     = JMP_NEXT;
			end
			// shift CV / 5, and phase advance
			PC_SHIFT: begin
				uw.asel     = A_SMAG;
				uw.bsel     = B_RECIP;
				uw.sq_we    = 1'b1;
				uw.phase_we = 1'b1;
				uw.jmp      = JMP_NEXT;
			end
			// gate compares into the output register
			PC_OUT: begin
				uw.out_we = 1'b1;
				uw.jmp    = JMP_END;
			end
			default: begin
				uw.jmp = JMP_END;
			end
		endcase
	end

endmodule

// ===== hdl/pscp_seq.sv =====
// Sequencer: step counter, loop counter, jumps and channel handshakes.
`include "phase_shifted_clock_pair_top_macros.svh"

module pscp_seq import pscp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	output logic   out_valid,
	input  logic   out_ready,
	input  ucode_t uw,
	output pc_t    pc,
	output ctl_t   ctl
);

	seq_state_t state_q, state_d;
	pc_t        pc_q;
	logic [1:0] k_q;
	logic       out_valid_q;
	logic       accept;
	logic       stall;
	logic       exec;

	// Output step waits while the previous result is still held
	assign stall  = uw.out_we && out_valid_q && !out_ready;
	assign exec   = (state_q == SEQ_RUN) && !stall;
	assign accept = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: if (accept) state_d = SEQ_RUN;
			SEQ_RUN:  if (exec && uw.jmp == JMP_END) state_d = SEQ_IDLE;
			default:  state_d = SEQ_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		case (state_q)
			SEQ_IDLE: in_ready = 1'b1;
			SEQ_RUN:  in_ready = 1'b0;
			default:  in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_HORNER;
			k_q  <= HORNER_LAST;
		end else if (accept) begin
			pc_q <= PC_HORNER;
			k_q  <= HORNER_LAST;
		end else if (exec) begin
			case (uw.jmp)
				JMP_NEXT: pc_q <= pc_q + 1'b1;
				JMP_LOOP: begin
					if (k_q != 2'd0) begin
						pc_q <= uw.target;
						k_q  <= k_q - 1'b1;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				JMP_END:  pc_q <= PC_HORNER;
				default:  pc_q <= PC_HORNER;
			endcase
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec && uw.out_we) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign pc        = pc_q;
	assign ctl       = '{load: accept, run: exec, uw: uw, k: k_q};

	`PSCP_ASSERT_IMP(a_no_overwrite, exec && uw.out_we, !out_valid_q || out_ready, "result overwritten before taken")
	`PSCP_ASSERT_NEXT(a_start, accept, state_q == SEQ_RUN && pc_q == PC_HORNER && k_q == HORNER_LAST, "program did not start at first step")
	`PSCP_ASSERT_IMP(a_valid_src, $rose(out_valid_q), $past(exec && uw.out_we), "result valid without output step")
	`PSCP_ASSERT_IMP(a_no_accept_busy, state_q == SEQ_RUN, !accept, "transaction accepted while busy")

endmodule

// ===== hdl/pscp_dp.sv =====
// Datapath: config registers, shared multiplier, accumulator, phase and gate compares.
module pscp_dp import pscp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic signed [15:0] rate_cv,
	input  logic               rate_cv_present,
	input  logic signed [15:0] shift_cv,
	input  logic               shift_cv_present,
	input  ctl_t               ctl,
	output logic               alpha_gate,
	output logic               beta_gate,
	output logic               combined_gate
);

	localparam int LOW_BITS = PHASE_BITS - 16;

	logic signed [14:0]    rate_knob_q;
	logic [16:0]           shift_knob_q;
	logic [15:0]           pulse_width_q;
	logic [31:0]           step_per_hz_q;

	logic [4:0]            ip_q;
	logic [10:0]           f_q;
	logic [19:0]           smag_q;
	logic                  sneg_q;
	logic                  spres_q;
	logic [30:0]           acc_q;
	logic [62:0]           prod_q;
	logic [17:0]           sq_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic                  alpha_q, beta_q;

	logic signed [17:0]    v_sum, v_clamp, v_off;
	logic [15:0]           cv_abs;
	logic [31:0]           mul_a, mul_b;
	logic [63:0]           prod;
	logic [31:0]           acc_sum;
	logic [5:0]            sh_amt;
	logic [62:0]           inc_full, inc_cap;
	logic [62:0]           half;
	logic signed [18:0]    sq_signed, s_sum, s_clamp;
	logic [16:0]           s_sel;
	logic [PHASE_BITS-1:0] sh_w, pw_w, off_w;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_knob_q   <= RATE_KNOB_RST;
			shift_knob_q  <= SHIFT_KNOB_RST;
			pulse_width_q <= PULSE_WIDTH_RST;
			step_per_hz_q <= STEP_PER_HZ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RATE_KNOB:   rate_knob_q   <= cfg_data[14:0];
				CFG_SHIFT_KNOB:  shift_knob_q  <= cfg_data[16:0];
				CFG_PULSE_WIDTH: pulse_width_q <= cfg_data[15:0];
				CFG_STEP_PER_HZ: step_per_hz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Rate volts: knob plus CV, clamped, split into octave and fraction
	always_comb begin
		v_sum = 18'(rate_knob_q);
		if (rate_cv_present) v_sum = v_sum + 18'(rate_cv);
		v_clamp = v_sum;
		if (v_sum > V_LIMIT)  v_clamp = V_LIMIT;
		if (v_sum < -V_LIMIT) v_clamp = -V_LIMIT;
		v_off = v_clamp + V_OFFSET;
	end

	// Shift CV magnitude times 16, plus 4 when negative for the floor
	assign cv_abs = shift_cv[15] ? 16'(-17'(shift_cv)) : 16'(shift_cv);

	// Shared multiplier
	always_comb begin
		case (ctl.uw.asel)
			A_ACC:   mul_a = 32'(acc_q);
			A_STEP:  mul_a = step_per_hz_q;
			A_SMAG:  mul_a = 32'(smag_q);
			default: mul_a = '0;
		endcase
		case (ctl.uw.bsel)
			B_F:     mul_b = 32'(f_q);
			B_ACC:   mul_b = 32'(acc_q);
			B_RECIP: mul_b = 32'(RECIP5);
			default: mul_b = '0;
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
	end

	// Horner accumulate
	always_comb begin
		case (ctl.uw.acc_op)
			ACC_COEF: acc_sum = 32'(exp_coef(ctl.k)) + 32'(prod[41:11]);
			ACC_ONE:  acc_sum = 32'(EXP_ONE) + 32'(prod[41:11]);
			default:  acc_sum = 32'(acc_q);
		endcase
	end

	// Phase increment: scale by octave, cap at half a cycle
	always_comb begin
		half     = 63'(1) << (PHASE_BITS - 1);
		sh_amt   = INC_SHIFT_BASE - {1'b0, ip_q};
		inc_full = prod_q >> sh_amt;
		inc_cap  = (inc_full > half) ? half : inc_full;
	end

	// Shift fraction and gate compares
	always_comb begin
		sq_signed = sneg_q ? -19'(sq_q) : 19'(sq_q);
		s_sum     = 19'(shift_knob_q) + sq_signed;
		s_clamp   = s_sum;
		if (s_sum < 19'sd0)    s_clamp = 19'sd0;
		if (s_sum > SHIFT_ONE) s_clamp = SHIFT_ONE;
		s_sel = spres_q ? s_clamp[16:0] : shift_knob_q;
		sh_w  = {s_sel[15:0], {LOW_BITS{1'b0}}};
		pw_w  = {pulse_width_q, {LOW_BITS{1'b0}}};
		off_w = phase_q - sh_w;
	end

	// Operand capture on accept; step results while running
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ip_q    <= v_off[15:11];
			f_q     <= v_off[10:0];
			smag_q  <= {cv_abs, 4'b0000} + (shift_cv[15] ? 20'd4 : 20'd0);
			sneg_q  <= shift_cv[15];
			spres_q <= shift_cv_present;
			acc_q   <= EXP_C4;
		end else if (ctl.run) begin
			if (ctl.uw.acc_op != ACC_HOLD) acc_q <= acc_sum[30:0];
			if (ctl.uw.prod_we)            prod_q <= prod[62:0];
			if (ctl.uw.sq_we)              sq_q <= prod[RECIP5_SHIFT+17:RECIP5_SHIFT];
			if (ctl.uw.out_we) begin
				alpha_q <= phase_q < pw_w;
				beta_q  <= off_w < pw_w;
			end
		end
	end

	// Phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (ctl.run && ctl.uw.phase_we) begin
			phase_q <= phase_q + inc_cap[PHASE_BITS-1:0];
		end
	end

	assign alpha_gate    = alpha_q;
	assign beta_gate     = beta_q;
	assign combined_gate = alpha_q | beta_q;

endmodule

// ===== hdl/phase_shifted_clock_pair_top.sv =====
// Program steps from sample accept to gate result valid: 4 Horner, mantissa, scale, shift, out.
// A new sample is accepted only when idle, after all 8 program steps of the previous one have run.
// The output register holds a result until taken; the final step waits while it is full.
// Reset (arst_n low, asynchronous): phase cleared, knobs to defaults, sequencer idle.
// No clearing pass; the sequencer is idle and ready for a sample as soon as reset is released.
module phase_shifted_clock_pair_top import pscp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data,
	pscp_sample_if.sink sample,
	pscp_gate_if.source gate
);

	pc_t    pc;
	ucode_t uw;
	ctl_t   ctl;

	// Control store
	pscp_ucode_rom u_rom (
		.pc (pc),
		.uw (uw)
	);

	// Step sequencer
	pscp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (gate.valid),
		.out_ready (gate.ready),
		.uw        (uw),
		.pc        (pc),
		.ctl       (ctl)
	);

	// Arithmetic
	pscp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.rate_cv          (sample.rate_cv),
		.rate_cv_present  (sample.rate_cv_present),
		.shift_cv         (sample.shift_cv),
		.shift_cv_present (sample.shift_cv_present),
		.ctl              (ctl),
		.alpha_gate       (gate.alpha_gate),
		.beta_gate        (gate.beta_gate),
		.combined_gate    (gate.combined_gate)
	);

endmodule
